[src/camera_vertex_projection_macros.svh]
// Assertion helpers for the vertex projection block.
`ifndef CAMERA_VERTEX_PROJECTION_MACROS_SVH
`define CAMERA_VERTEX_PROJECTION_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CVP_ASSERT_SAME(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("camera_vertex_projection: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CVP_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("camera_vertex_projection: assertion failed");

`else

`define CVP_ASSERT_SAME(name, cond, prop)
`define CVP_ASSERT_NEXT(name, cond, prop)

`endif

`endif

[src/cvp_pkg.sv]
`default_nettype none

package cvp_pkg;

    localparam int PT_W    = 21;
    localparam int DIFF_W  = 22;
    localparam int COMP_W  = 18;
    localparam int PROD_W  = 40;
    localparam int VIEW_W  = 42;
    localparam int NUM_W   = 58;
    localparam int QUO_W   = 32;
    localparam int CMP_W   = 74;
    localparam int SCALE_W = 24;
    localparam int SIZE_W  = 13;
    localparam int CFG_W   = 63;
    localparam int WIDE_W  = 56;

    localparam logic [2:0] CFG_BASIS_U  = 3'd0;
    localparam logic [2:0] CFG_BASIS_V  = 3'd1;
    localparam logic [2:0] CFG_BASIS_N  = 3'd2;
    localparam logic [2:0] CFG_CENTER   = 3'd3;
    localparam logic [2:0] CFG_SCALE_X  = 3'd4;
    localparam logic [2:0] CFG_SCALE_Y  = 3'd5;
    localparam logic [2:0] CFG_WIDTH    = 3'd6;
    localparam logic [2:0] CFG_HEIGHT   = 3'd7;

    typedef struct packed {
        logic                    zero;
        logic signed [PT_W-1:0]  depth;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0]  rx;
        logic [NUM_W-1:0]  ry;
        logic [QUO_W-1:0]  qx;
        logic [QUO_W-1:0]  qy;
        logic [VIEW_W-1:0] d;
        logic              negx;
        logic              negy;
        logic              ovfx;
        logic              ovfy;
        side_t             side;
    } div_t;

    // Saturate a wide signed value to the 21-bit output range.
    function automatic logic signed [PT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(signed'({1'b0, {(PT_W-1){1'b1}}}));
        lo = -hi - WIDE_W'(1);
        priority if (x > hi) sat_out = hi[PT_W-1:0];
        else if (x < lo)     sat_out = lo[PT_W-1:0];
        else                 sat_out = x[PT_W-1:0];
    endfunction

    // One restoring step; the quotient bit shifts in from the right.
    function automatic void rstep(inout logic [NUM_W-1:0] r, inout logic [QUO_W-1:0] q,
                                  input logic [VIEW_W-1:0] d, input logic [4:0] sh);
        logic [CMP_W-1:0] dsh;
        dsh = {{(CMP_W-VIEW_W){1'b0}}, d} << sh;
        if ({{(CMP_W-NUM_W){1'b0}}, r} >= dsh)
        begin
            r = r - dsh[NUM_W-1:0];
            q = {q[QUO_W-2:0], 1'b1};
        end
        else
        begin
            q = {q[QUO_W-2:0], 1'b0};
        end
    endfunction

    function automatic div_t div_step(input div_t s, input logic [4:0] sh);
        div_t o;
        logic [NUM_W-1:0] r;
        logic [QUO_W-1:0] q;
        o = s;
        r = s.rx;
        q = s.qx;
        rstep(r, q, s.d, sh);
        o.rx = r;
        o.qx = q;
        r = s.ry;
        q = s.qy;
        rstep(r, q, s.d, sh);
        o.ry = r;
        o.qy = q;
        return o;
    endfunction

    function automatic logic signed [QUO_W-1:0] ratio_sat(input logic [QUO_W-1:0] q,
                                                          input logic neg, input logic ovf);
        logic [QUO_W-1:0] lim;
        lim = {1'b1, {(QUO_W-1){1'b0}}};
        priority if (neg && (ovf || q > lim)) ratio_sat = lim;
        else if (neg)                         ratio_sat = -q;
        else if (ovf || q >= lim)             ratio_sat = lim - QUO_W'(1);
        else                                  ratio_sat = q;
    endfunction

endpackage

`default_nettype wire

[src/camera_vertex_projection.sv]
// Perspective projection of world points to screen pixels. One point may enter every clock
// cycle. The pipeline is built around the 32-stage restoring divider that forms the
// view-space ratios, one quotient bit per stage, with the subtract, rotate, scale and
// pixel mapping steps in the stages around it. A stall at the output fills the empty
// stages first and only then holds the input. The
// configuration registers are written through the plain write port and must only be
// changed while no point is in flight.
`default_nettype none
`include "camera_vertex_projection_macros.svh"

module camera_vertex_projection (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [2:0]                             cfg_index,
    input  wire logic [cvp_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [cvp_pkg::PT_W-1:0]        world_x,
    input  wire logic signed [cvp_pkg::PT_W-1:0]        world_y,
    input  wire logic signed [cvp_pkg::PT_W-1:0]        world_z,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [cvp_pkg::PT_W-1:0]             pixel_col,
    output logic signed [cvp_pkg::PT_W-1:0]             pixel_row,
    output logic signed [cvp_pkg::PT_W-1:0]             view_depth,
    output logic                                        depth_zero
);
    import cvp_pkg::*;

    localparam int NDIV   = 32;
    localparam int NST    = NDIV + 10;
    localparam int DIV0   = 5;
    localparam int ST_RAT = DIV0 + NDIV;

    // Configuration registers.
    logic [3*COMP_W-1:0]        basis_u_reg, basis_v_reg, basis_n_reg;
    logic [CFG_W-1:0]           center_reg;
    logic signed [SCALE_W-1:0]  scale_x_reg, scale_y_reg;
    logic [SIZE_W-1:0]          width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_u_reg <= '0;
            basis_v_reg <= '0;
            basis_n_reg <= '0;
            center_reg  <= '0;
            scale_x_reg <= SCALE_W'(163840);
            scale_y_reg <= SCALE_W'(163840);
            width_reg   <= SIZE_W'(640);
            height_reg  <= SIZE_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASIS_U: basis_u_reg <= cfg_data[3*COMP_W-1:0];
                CFG_BASIS_V: basis_v_reg <= cfg_data[3*COMP_W-1:0];
                CFG_BASIS_N: basis_n_reg <= cfg_data[3*COMP_W-1:0];
                CFG_CENTER:  center_reg  <= cfg_data;
                CFG_SCALE_X: scale_x_reg <= cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y: scale_y_reg <= cfg_data[SCALE_W-1:0];
                CFG_WIDTH:   width_reg   <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:  height_reg  <= cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    // Valid bits and the ready chain: a stage loads when it is empty or its successor loads.
    logic [NST-1:0] valid_reg, valid_next;
    logic [NST:0]   rdy;

    assign rdy[NST] = out_ready;
    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_rdy
            assign rdy[g] = !valid_reg[g] || rdy[g+1];
        end
    endgenerate

    always_comb
    begin
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NST-1];

    // Stage 0: offset from the camera centre.
    logic signed [DIFF_W-1:0] w_reg [3];
    logic signed [PT_W-1:0]   pt [3];
    assign pt[0] = world_x;
    assign pt[1] = world_y;
    assign pt[2] = world_z;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i] <= DIFF_W'(pt[i]) - DIFF_W'(signed'(center_reg[PT_W*i +: PT_W]));
            end
        end
    end

    // Stage 1: the nine products of the rotation.
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic [3*COMP_W-1:0]      rows [3];
    assign rows[0] = basis_u_reg;
    assign rows[1] = basis_v_reg;
    assign rows[2] = basis_n_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= PROD_W'(signed'(rows[r][COMP_W*c +: COMP_W]) * w_reg[c]);
                end
            end
        end
    end

    // Stage 2: view coordinates.
    logic signed [VIEW_W-1:0] view_reg [3];

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int r = 0; r < 3; r++)
            begin
                view_reg[r] <= VIEW_W'(prod_reg[r][0]) + VIEW_W'(prod_reg[r][1])
                             + VIEW_W'(prod_reg[r][2]);
            end
        end
    end

    // Stage 3: magnitudes and signs for the divider, rounded depth.
    div_t s3_reg, s3_next;
    logic signed [VIEW_W:0]   depth_sum;
    logic signed [VIEW_W:0]   depth_shift;
    logic [VIEW_W-1:0]        abs_x, abs_y;

    always_comb
    begin
        abs_x       = view_reg[0][VIEW_W-1] ? VIEW_W'(-view_reg[0]) : view_reg[0];
        abs_y       = view_reg[1][VIEW_W-1] ? VIEW_W'(-view_reg[1]) : view_reg[1];
        depth_sum   = (VIEW_W+1)'(view_reg[2]) + (VIEW_W+1)'(32768);
        depth_shift = depth_sum >>> 16;
        s3_next.rx  = {abs_x[NUM_W-17:0], 16'b0};
        s3_next.ry  = {abs_y[NUM_W-17:0], 16'b0};
        s3_next.qx  = '0;
        s3_next.qy  = '0;
        s3_next.d   = view_reg[2][VIEW_W-1] ? VIEW_W'(-view_reg[2]) : view_reg[2];
        s3_next.negx = view_reg[0][VIEW_W-1] ^ view_reg[2][VIEW_W-1];
        s3_next.negy = view_reg[1][VIEW_W-1] ^ view_reg[2][VIEW_W-1];
        s3_next.ovfx = 1'b0;
        s3_next.ovfy = 1'b0;
        s3_next.side.zero  = (view_reg[2] == '0);
        s3_next.side.depth = sat_out(WIDE_W'(depth_shift));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
            s3_reg <= s3_next;
    end

    // Stage 4: a quotient that needs more than 32 bits saturates.
    div_t s4_reg, s4_next;

    always_comb
    begin
        s4_next      = s3_reg;
        s4_next.ovfx = {{(CMP_W-NUM_W){1'b0}}, s3_reg.rx} >= {s3_reg.d, 32'b0};
        s4_next.ovfy = {{(CMP_W-NUM_W){1'b0}}, s3_reg.ry} >= {s3_reg.d, 32'b0};
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
            s4_reg <= s4_next;
    end

    // Divider: one quotient bit per stage, most significant first.
    div_t div_reg [NDIV];
    div_t div_next [NDIV];

    always_comb
    begin
        div_next[0] = div_step(s4_reg, 5'(NDIV-1));
        for (int k = 1; k < NDIV; k++)
        begin
            div_next[k] = div_step(div_reg[k-1], 5'(NDIV-1-k));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NDIV; k++)
        begin
            if (rdy[DIV0+k])
                div_reg[k] <= div_next[k];
        end
    end

    // Stage: saturated signed ratios.
    logic signed [QUO_W-1:0] rat_x_reg, rat_y_reg;
    side_t                   rat_side_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_RAT])
        begin
            rat_x_reg    <= ratio_sat(div_reg[NDIV-1].qx, div_reg[NDIV-1].negx,
                                      div_reg[NDIV-1].ovfx);
            rat_y_reg    <= ratio_sat(div_reg[NDIV-1].qy, div_reg[NDIV-1].negy,
                                      div_reg[NDIV-1].ovfy);
            rat_side_reg <= div_reg[NDIV-1].side;
        end
    end

    // Stage: perspective scaling.
    logic signed [WIDE_W-1:0] sc_x_reg, sc_y_reg;
    side_t                    sc_side_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_RAT+1])
        begin
            sc_x_reg    <= WIDE_W'(scale_x_reg * rat_x_reg);
            sc_y_reg    <= WIDE_W'(scale_y_reg * rat_y_reg);
            sc_side_reg <= rat_side_reg;
        end
    end

    // Stage: floor to Q.16 and shift the range from [-1, 1] to [0, 2].
    logic signed [PROD_W:0] off_x_reg, off_y_reg;
    side_t                  off_side_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_RAT+2])
        begin
            off_x_reg    <= (PROD_W+1)'(signed'(sc_x_reg[WIDE_W-1:16])) + (PROD_W+1)'(65536);
            off_y_reg    <= (PROD_W+1)'(signed'(sc_y_reg[WIDE_W-1:16])) + (PROD_W+1)'(65536);
            off_side_reg <= sc_side_reg;
        end
    end

    // Stage: scale to the screen size; the row uses the halved height.
    logic signed [PROD_W+SIZE_W+1:0] mul_x_reg;
    logic signed [PROD_W+SIZE_W:0]   mul_y_reg;
    logic [SIZE_W-1:0]               height_m_reg;
    side_t                           mul_side_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_RAT+3])
        begin
            mul_x_reg    <= off_x_reg * signed'({1'b0, width_reg});
            mul_y_reg    <= off_y_reg * signed'({1'b0, height_reg[SIZE_W-1:1]});
            height_m_reg <= height_reg;
            mul_side_reg <= off_side_reg;
        end
    end

    // Output stage: round to pixels, flip the row and saturate.
    logic signed [WIDE_W-1:0] col_sum, row_sum;

    always_comb
    begin
        col_sum = (WIDE_W'(mul_x_reg) + WIDE_W'(65536)) >>> 17;
        row_sum = (WIDE_W'(signed'({1'b0, height_m_reg, 16'b0})) + WIDE_W'(32768)
                   - WIDE_W'(mul_y_reg)) >>> 16;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NST-1])
        begin
            pixel_col  <= mul_side_reg.zero ? '0 : sat_out(col_sum);
            pixel_row  <= mul_side_reg.zero ? '0 : sat_out(row_sum);
            view_depth <= mul_side_reg.depth;
            depth_zero <= mul_side_reg.zero;
        end
    end

    `CVP_ASSERT_SAME(a_zero_clears_pixels, out_valid && depth_zero, pixel_col == '0 && pixel_row == '0)
    `CVP_ASSERT_SAME(a_empty_output_ready, !out_valid, in_ready)
    `CVP_ASSERT_SAME(a_zero_depth_rounds, valid_reg[3] && s3_reg.side.zero, s3_reg.side.depth == '0)
    `CVP_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, valid_reg[0])

endmodule

`default_nettype wire

[verif/camera_vertex_projection_test.sv]
`timescale 1ns / 100ps

module camera_vertex_projection_test;
    import cvp_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic signed [PT_W-1:0] col;
        logic signed [PT_W-1:0] row;
        logic signed [PT_W-1:0] depth;
        logic                   zero;
    } pixel_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [2:0]             cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [PT_W-1:0] world_x;
    logic signed [PT_W-1:0] world_y;
    logic signed [PT_W-1:0] world_z;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [PT_W-1:0] pixel_col;
    logic signed [PT_W-1:0] pixel_row;
    logic signed [PT_W-1:0] view_depth;
    logic                   depth_zero;

    // Local copy of the camera registers.
    logic [53:0]              row_u;
    logic [53:0]              row_v;
    logic [53:0]              row_n;
    logic [CFG_W-1:0]         centre;
    logic signed [SCALE_W-1:0] gain_x;
    logic signed [SCALE_W-1:0] gain_y;
    logic [SIZE_W-1:0]        scr_w;
    logic [SIZE_W-1:0]        scr_h;

    pixel_t pending_pixels[$];
    int     fault_count;
    int     pixels_checked;
    int     zero_depth_seen;
    int     points_sent;
    int     sender_idle_pct;
    int     receiver_idle_pct;
    int     hold_request;
    int     hold_left;
    int     quiet_cycles;

    camera_vertex_projection u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .out_valid(out_valid), .out_ready(out_ready), .pixel_col(pixel_col),
        .pixel_row(pixel_row), .view_depth(view_depth), .depth_zero(depth_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clamp21(longint x);
        if (x > 1048575)
            return 1048575;
        if (x < -1048576)
            return -1048576;
        return x;
    endfunction

    function automatic longint row_dot(logic [53:0] r, longint a, longint b, longint c);
        return longint'($signed(r[17:0])) * a + longint'($signed(r[35:18])) * b
             + longint'($signed(r[53:36])) * c;
    endfunction

    function automatic longint view_ratio(longint n, longint d);
        longint q;
        q = (n * 65536) / d;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q;
    endfunction

    function automatic pixel_t project_point(logic signed [PT_W-1:0] px,
                                             logic signed [PT_W-1:0] py,
                                             logic signed [PT_W-1:0] pz);
        longint dx, dy, dz, vx, vy, vz, qx, qy, wd, ht, col, row;
        pixel_t p;
        dx = longint'(px) - longint'($signed(centre[20:0]));
        dy = longint'(py) - longint'($signed(centre[41:21]));
        dz = longint'(pz) - longint'($signed(centre[62:42]));
        vx = row_dot(row_u, dx, dy, dz);
        vy = row_dot(row_v, dx, dy, dz);
        vz = row_dot(row_n, dx, dy, dz);
        col = 0;
        row = 0;
        if (vz != 0)
        begin
            qx = (longint'(gain_x) * view_ratio(vx, vz)) >>> 16;
            qy = (longint'(gain_y) * view_ratio(vy, vz)) >>> 16;
            wd = longint'(scr_w);
            ht = longint'(scr_h);
            col = clamp21(((qx + 65536) * wd + 65536) >>> 17);
            row = clamp21((ht * 65536 + 32768 - (qy + 65536) * (ht / 2)) >>> 16);
        end
        p.col = col[PT_W-1:0];
        p.row = row[PT_W-1:0];
        p.depth = PT_W'(clamp21((vz + 32768) >>> 16));
        p.zero = (vz == 0);
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        fault_count++;
    endtask

    // Receiver side: random back-pressure plus an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_request > 0 && hold_left == 0)
        begin
            hold_left <= hold_request;
            hold_request = 0;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("result transaction with no point outstanding");
                fault_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (want.zero)
                    zero_depth_seen++;
                if (depth_zero !== want.zero)
                    report_mismatch("depth_zero", depth_zero, want.zero);
                if (view_depth !== want.depth)
                    report_mismatch("view_depth", view_depth, want.depth);
                if (pixel_col !== want.col)
                    report_mismatch("pixel_col", pixel_col, want.col);
                if (pixel_row !== want.row)
                    report_mismatch("pixel_row", pixel_row, want.row);
            end
        end
    end

    // Watchdog: only counts while something is offered or outstanding.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (!in_valid && pending_pixels.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_point(logic signed [PT_W-1:0] px, logic signed [PT_W-1:0] py,
                              logic signed [PT_W-1:0] pz);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        world_x <= px;
        world_y <= py;
        world_z <= pz;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pixels.push_back(project_point(px, py, pz));
        points_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_BASIS_U: row_u = value[53:0];
            CFG_BASIS_V: row_v = value[53:0];
            CFG_BASIS_N: row_n = value[53:0];
            CFG_CENTER:  centre = value;
            CFG_SCALE_X: gain_x = value[SCALE_W-1:0];
            CFG_SCALE_Y: gain_y = value[SCALE_W-1:0];
            CFG_WIDTH:   scr_w = value[SIZE_W-1:0];
            default:     scr_h = value[SIZE_W-1:0];
        endcase
    endtask

    function automatic logic [CFG_W-1:0] pack_row(int a, int b, int c);
        logic [CFG_W-1:0] v;
        v = CFG_W'({$urandom, $urandom});
        v[17:0] = a[17:0];
        v[35:18] = b[17:0];
        v[53:36] = c[17:0];
        return v;
    endfunction

    task automatic set_camera(int ux, int uy, int uz, int vx, int vy, int vz,
                              int nx, int ny, int nz, logic [CFG_W-1:0] ctr,
                              int sx, int sy, int w, int h);
        write_reg(CFG_BASIS_U, pack_row(ux, uy, uz));
        write_reg(CFG_BASIS_V, pack_row(vx, vy, vz));
        write_reg(CFG_BASIS_N, pack_row(nx, ny, nz));
        write_reg(CFG_CENTER, ctr);
        write_reg(CFG_SCALE_X, {{39{1'b1}}, sx[23:0]});
        write_reg(CFG_SCALE_Y, {39'd0, sy[23:0]});
        write_reg(CFG_WIDTH, CFG_W'({$urandom, $urandom, 19'd0}) | CFG_W'(w & 8191));
        write_reg(CFG_HEIGHT, CFG_W'(h & 8191));
    endtask

    function automatic int rand_comp();
        case ($urandom_range(3))
            0: return $urandom_range(0, 1) ? 131071 : -131072;
            1: return $urandom_range(0, 131072) - 65536;
            default: return int'($urandom) >>> 14;
        endcase
    endfunction

    task automatic random_camera();
        int sizes[4];
        sizes = '{0, 1, 4096, 8191};
        set_camera(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   CFG_W'({$urandom, $urandom}),
                   ($urandom_range(3) == 0) ? int'($urandom) : $urandom_range(0, 600000) - 300000,
                   ($urandom_range(3) == 0) ? int'($urandom) : $urandom_range(0, 600000) - 300000,
                   ($urandom_range(4) == 0) ? sizes[$urandom_range(3)] : $urandom_range(1, 4096),
                   ($urandom_range(4) == 0) ? sizes[$urandom_range(3)] : $urandom_range(1, 4096));
    endtask

    // Mostly points around the camera centre, with full-range noise mixed in.
    task automatic random_points(int count);
        logic signed [PT_W-1:0] cx, cy, cz;
        int k;
        cx = centre[20:0];
        cy = centre[41:21];
        cz = centre[62:42];
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(9))
                0, 1: send_point(PT_W'($urandom), PT_W'($urandom), PT_W'($urandom));
                2: send_point(cx, cy, cz);
                default: send_point(cx + PT_W'($urandom_range(0, 65535) - 32768),
                                    cy + PT_W'($urandom_range(0, 65535) - 32768),
                                    cz + PT_W'($urandom_range(0, 65535) - 32768));
            endcase
        end
    endtask

    task automatic test_reset_basis();
        send_point(21'sd0, 21'sd0, 21'sd0);
        send_point(21'sd1048575, -21'sd1048576, 21'sd12345);
        send_point(-21'sd1, 21'sd1, 21'sd1048575);
        wait_drained();
    endtask

    task automatic test_directed();
        set_camera(65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 63'd0, 163840, 163840, 640, 480);
        send_point(21'sd0, 21'sd0, 21'sd256);
        send_point(21'sd256, -21'sd256, 21'sd256);
        send_point(21'sd1048575, 21'sd1048575, 21'sd1048575);
        send_point(-21'sd1048576, -21'sd1048576, -21'sd1048576);
        send_point(21'sd1048575, -21'sd1048576, 21'sd1);
        send_point(-21'sd1048576, 21'sd1048575, -21'sd1);
        send_point(21'sd500, 21'sd500, 21'sd0);
        send_point(21'sd1000, -21'sd300, -21'sd256);
        wait_drained();
        // Zero screen width, odd height and a negative x scale, with a shifted, tilted camera.
        set_camera(-131072, 131071, 1, 131071, -131072, -1, 1, -1, -131072,
                   {21'h100000, 21'h0FFFFF, 21'h000100}, -8388608, 8388607, 0, 4097);
        send_point(21'sd0, 21'sd0, 21'sd0);
        send_point(21'h000100, 21'h0FFFFF, 21'h100000);
        send_point(21'sd1048575, 21'sd1048575, 21'sd1048575);
        send_point(-21'sd1048576, -21'sd1048576, -21'sd1048576);
        send_point(21'sd300, 21'sd300, 21'sd300);
        wait_drained();
        set_camera(65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 63'd0, 8388607, -8388608, 8191, 0);
        send_point(21'sd777, -21'sd777, 21'sd1);
        send_point(-21'sd1048576, 21'sd1048575, 21'sd256);
        send_point(21'sd12, 21'sd34, -21'sd1);
        wait_drained();
    endtask

    task automatic test_idle_modes(int send_pct, int recv_pct);
        int r;
        sender_idle_pct = send_pct;
        receiver_idle_pct = recv_pct;
        for (r = 0; r < 3; r++)
        begin
            random_camera();
            random_points(100);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        random_camera();
        hold_request = 400;
        random_points(120);
        wait_drained();
        // The sender stops until every result has come, then carries on.
        random_points(40);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BASIS_U;
        cfg_data = '0;
        in_valid = 1'b0;
        world_x = '0;
        world_y = '0;
        world_z = '0;
        row_u = '0;
        row_v = '0;
        row_n = '0;
        centre = '0;
        gain_x = 24'sd163840;
        gain_y = 24'sd163840;
        scr_w = 13'd640;
        scr_h = 13'd480;
        fault_count = 0;
        pixels_checked = 0;
        zero_depth_seen = 0;
        points_sent = 0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_request = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_basis();
        test_directed();
        test_idle_modes(15, 47);
        test_idle_modes(47, 15);
        test_idle_modes(0, 0);
        test_backpressure();
        sender_idle_pct = 0;
        receiver_idle_pct = 30;
        test_backpressure();

        $display("projected %0d points through %0d camera settings; %0d results checked,",
                 points_sent, 15, pixels_checked);
        $display("%0d of them at zero view depth, including long output stalls.",
                 zero_depth_seen);
        if (fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
